// ----- rtl/core/multi_pattern_match_counter_assert.svh -----
// Assertion macros used by the block's sequencer.
// Both expect clk_i and rst_ni in scope.
`ifndef MULTI_PATTERN_MATCH_COUNTER_ASSERT_SVH
`define MULTI_PATTERN_MATCH_COUNTER_ASSERT_SVH

// Check a property on every rising clock edge outside reset.
`define MPMC_ASSERT(lbl, prop) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) \
    else $error("mpmc assertion failed");

// Check that an antecedent implies a consequent in the same cycle.
`define MPMC_ASSERT_IMP(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error("mpmc implication failed");

`endif

// ----- rtl/core/mpmc_pkg.sv -----
// ----------------------------------------------------------------------------
// mpmc_pkg
// Shared constants, codes and store request/response types of the
// multi-pattern match counter.
// ----------------------------------------------------------------------------
package mpmc_pkg;

  localparam int MAX_NODES   = 4096;
  localparam int ALPHABET    = 26;
  localparam int NODE_W      = $clog2(MAX_NODES);
  localparam int USED_W      = $clog2(MAX_NODES + 1);
  localparam int CHILD_DEPTH = MAX_NODES * ALPHABET;
  localparam int CHILD_AW    = $clog2(CHILD_DEPTH);
  localparam int OP_W        = 2;
  localparam int SYM_W       = 5;
  localparam int STATUS_W    = 2;
  localparam int COUNT_W     = 16;
  localparam int TOTAL_W     = 48;

  localparam logic [OP_W-1:0] OP_INSERT = 2'd0;
  localparam logic [OP_W-1:0] OP_DELETE = 2'd1;

  localparam logic [STATUS_W-1:0] ST_OK      = 2'd0;
  localparam logic [STATUS_W-1:0] ST_FULL    = 2'd1;
  localparam logic [STATUS_W-1:0] ST_MISSING = 2'd2;

  typedef struct packed {
    logic [CHILD_AW-1:0] child_raddr;
    logic                child_we;
    logic [CHILD_AW-1:0] child_waddr;
    logic [NODE_W-1:0]   child_wdata;
    logic [NODE_W-1:0]   fail_raddr;
    logic                fail_we;
    logic [NODE_W-1:0]   fail_waddr;
    logic [NODE_W-1:0]   fail_wdata;
    logic [NODE_W-1:0]   own_raddr;
    logic                own_we;
    logic [NODE_W-1:0]   own_waddr;
    logic [COUNT_W-1:0]  own_wdata;
    logic [NODE_W-1:0]   prop_raddr;
    logic                prop_we;
    logic [NODE_W-1:0]   prop_waddr;
    logic [COUNT_W-1:0]  prop_wdata;
    logic [NODE_W-1:0]   q_raddr;
    logic                q_we;
    logic [NODE_W-1:0]   q_waddr;
    logic [NODE_W-1:0]   q_wdata;
  } mpmc_req_t;

  typedef struct packed {
    logic                ready;
    logic [NODE_W-1:0]   child;
    logic [NODE_W-1:0]   fail;
    logic [COUNT_W-1:0]  own;
    logic [COUNT_W-1:0]  prop;
    logic [NODE_W-1:0]   q;
  } mpmc_rsp_t;

  // Flat index of a node's child slot for one symbol.
  function automatic logic [CHILD_AW-1:0] child_idx(logic [NODE_W-1:0] node,
                                                    logic [SYM_W-1:0] sym);
    return CHILD_AW'(CHILD_AW'(node) * CHILD_AW'(ALPHABET) + CHILD_AW'(sym));
  endfunction

endpackage

// ----- rtl/core/multi_pattern_match_counter.sv -----
// ----------------------------------------------------------------------------
// multi_pattern_match_counter
// Aho-Corasick pattern store and match counter over a 26-letter alphabet.
// ----------------------------------------------------------------------------
// Usage: after reset the node store is swept clear and the input is not
// ready. Each word then works through the node store in steps: a pattern
// word reads its child slot and may allocate a node, and the last word of
// a pattern that reaches its node also adjusts its end count; a text word
// follows goto or failure links and adds the propagated count of the node
// it reaches. The last word of a pattern adds a breadth-first rebuild that
// takes each node from the queue, examines its child slots and follows
// failure links to link each child that is not directly under the root.
// One word is in flight at a time; a finished result waits in the output
// register while the next word is taken, and a word whose result finds that
// register still full stalls until the receiver takes it.
module multi_pattern_match_counter (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          in_valid_i,
  output logic                          in_ready_o,
  input  logic [mpmc_pkg::OP_W-1:0]     operation_i,
  input  logic [mpmc_pkg::SYM_W-1:0]    symbol_i,
  input  logic                          last_i,
  output logic                          out_valid_o,
  input  logic                          out_ready_i,
  output logic [mpmc_pkg::STATUS_W-1:0] status_o,
  output logic [mpmc_pkg::TOTAL_W-1:0]  match_total_o,
  output logic                          result_last_o
);
  import mpmc_pkg::*;

  mpmc_req_t req;
  mpmc_rsp_t rsp;

  // Sequencer
  mpmc_seq u_seq (
    .clk_i, .rst_ni, .in_valid_i, .in_ready_o, .operation_i, .symbol_i, .last_i,
    .out_valid_o, .out_ready_i, .status_o, .match_total_o, .result_last_o,
    .req_o(req), .rsp_i(rsp)
  );

  // Node store
  mpmc_store u_store (
    .clk_i, .rst_ni, .req_i(req), .rsp_o(rsp)
  );

endmodule

// ----- rtl/core/mpmc_store.sv -----
// ----------------------------------------------------------------------------
// mpmc_store
// Node store: child table, failure links, end and propagated counts, walk queue,
// each one write and a registered read port. All but the queue clear at reset.
// ----------------------------------------------------------------------------
module mpmc_store (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  mpmc_pkg::mpmc_req_t req_i,
  output mpmc_pkg::mpmc_rsp_t rsp_o
);
  import mpmc_pkg::*;

  logic [NODE_W-1:0]  child_mem [CHILD_DEPTH];
  logic [NODE_W-1:0]  fail_mem  [MAX_NODES];
  logic [COUNT_W-1:0] own_mem   [MAX_NODES];
  logic [COUNT_W-1:0] prop_mem  [MAX_NODES];
  logic [NODE_W-1:0]  q_mem     [MAX_NODES];

  logic [CHILD_AW-1:0] clr_idx_q;
  logic                clr_busy_q;
  logic                clr_node;

  logic [NODE_W-1:0]   child_rd_q;
  logic [NODE_W-1:0]   fail_rd_q;
  logic [COUNT_W-1:0]  own_rd_q;
  logic [COUNT_W-1:0]  prop_rd_q;
  logic [NODE_W-1:0]   q_rd_q;

  assign clr_node = 32'(clr_idx_q) < MAX_NODES;

  // Sweep every table but the walk queue once after reset
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      clr_idx_q  <= '0;
      clr_busy_q <= 1'b1;
    end else if (clr_busy_q) begin
      if (32'(clr_idx_q) == CHILD_DEPTH - 1) begin
        clr_busy_q <= 1'b0;
      end else begin
        clr_idx_q <= clr_idx_q + 1'b1;
      end
    end
  end

  // Write: clearing pass first, then requests
  always_ff @(posedge clk_i) begin
    if (clr_busy_q) begin
      child_mem[clr_idx_q] <= '0;
      if (clr_node) begin
        fail_mem[clr_idx_q[NODE_W-1:0]] <= '0;
        own_mem[clr_idx_q[NODE_W-1:0]]  <= '0;
        prop_mem[clr_idx_q[NODE_W-1:0]] <= '0;
      end
    end else begin
      if (req_i.child_we) child_mem[req_i.child_waddr] <= req_i.child_wdata;
      if (req_i.fail_we)  fail_mem[req_i.fail_waddr]   <= req_i.fail_wdata;
      if (req_i.own_we)   own_mem[req_i.own_waddr]     <= req_i.own_wdata;
      if (req_i.prop_we)  prop_mem[req_i.prop_waddr]   <= req_i.prop_wdata;
      if (req_i.q_we)     q_mem[req_i.q_waddr]         <= req_i.q_wdata;
    end
  end

  // Registered reads
  always_ff @(posedge clk_i) begin
    child_rd_q <= child_mem[req_i.child_raddr];
    fail_rd_q  <= fail_mem[req_i.fail_raddr];
    own_rd_q   <= own_mem[req_i.own_raddr];
    prop_rd_q  <= prop_mem[req_i.prop_raddr];
    q_rd_q     <= q_mem[req_i.q_raddr];
  end

  assign rsp_o = '{ready: !clr_busy_q, child: child_rd_q, fail: fail_rd_q,
                   own: own_rd_q, prop: prop_rd_q, q: q_rd_q};

endmodule

// ----- rtl/core/mpmc_seq.sv -----
// ----------------------------------------------------------------------------
// mpmc_seq
// Sequencer: pattern insert/delete, text walk and breadth-first link rebuild,
// all through the node store's per-table read and write ports.
// ----------------------------------------------------------------------------
`include "multi_pattern_match_counter_assert.svh"

module mpmc_seq (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            in_valid_i,
  output logic                            in_ready_o,
  input  logic [mpmc_pkg::OP_W-1:0]       operation_i,
  input  logic [mpmc_pkg::SYM_W-1:0]      symbol_i,
  input  logic                            last_i,
  output logic                            out_valid_o,
  input  logic                            out_ready_i,
  output logic [mpmc_pkg::STATUS_W-1:0]   status_o,
  output logic [mpmc_pkg::TOTAL_W-1:0]    match_total_o,
  output logic                            result_last_o,
  output mpmc_pkg::mpmc_req_t             req_o,
  input  mpmc_pkg::mpmc_rsp_t             rsp_i
);
  import mpmc_pkg::*;

  typedef enum logic [18:0] {
    S_IDLE  = 19'h00001,
    S_P_RD  = 19'h00002,
    S_P_CHK = 19'h00004,
    S_P_CNT = 19'h00008,
    S_T_RD  = 19'h00010,
    S_T_CHK = 19'h00020,
    S_T_FL  = 19'h00040,
    S_T_ADD = 19'h00080,
    S_B_INI = 19'h00100,
    S_B_POP = 19'h00200,
    S_B_U   = 19'h00400,
    S_B_FU  = 19'h00800,
    S_B_C   = 19'h01000,
    S_B_V   = 19'h02000,
    S_B_JC  = 19'h04000,
    S_B_JF  = 19'h08000,
    S_B_P   = 19'h10000,
    S_B_W   = 19'h20000,
    S_FIN   = 19'h40000
  } state_e;

  state_e state_q, state_d;

  logic [OP_W-1:0]     op_q, op_d;
  logic [SYM_W-1:0]    sym_q, sym_d;
  logic                last_q, last_d;
  logic [USED_W-1:0]   used_q, used_d;
  logic [NODE_W-1:0]   pcur_q, pcur_d;
  logic                failed_q, failed_d;
  logic [NODE_W-1:0]   tcur_q, tcur_d;
  logic [TOTAL_W-1:0]  total_q, total_d;
  logic [USED_W-1:0]   head_q, head_d, tail_q, tail_d;
  logic [NODE_W-1:0]   u_q, u_d, fu_q, fu_d, v_q, v_d, l_q, l_d, j_q, j_d;
  logic [SYM_W-1:0]    i_q, i_d;
  logic [STATUS_W-1:0] rstat_q, rstat_d;
  logic [TOTAL_W-1:0]  rtot_q, rtot_d;
  logic                ovalid_q, ovalid_d;
  logic [STATUS_W-1:0] ostat_q, ostat_d;
  logic [TOTAL_W-1:0]  otot_q, otot_d;
  logic                olast_q, olast_d;

  logic                  is_pat, in_acc, pf;
  logic [STATUS_W-1:0]   code;
  logic [NODE_W-1:0]     nx;
  logic [COUNT_W:0]      psum;
  logic [TOTAL_W:0]      tsum;
  logic [TOTAL_W-1:0]    tsat;
  logic [SYM_W-1:0]      i_last;

  assign is_pat = (op_q == OP_INSERT) || (op_q == OP_DELETE);
  assign code   = (op_q == OP_INSERT) ? ST_FULL : ST_MISSING;
  assign in_acc = in_valid_i && in_ready_o;
  assign in_ready_o = (state_q == S_IDLE) && rsp_i.ready;
  assign psum   = {1'b0, rsp_i.own} + {1'b0, rsp_i.prop};
  assign tsum   = {1'b0, total_q} + (TOTAL_W + 1)'(rsp_i.prop);
  assign tsat   = tsum[TOTAL_W] ? '1 : tsum[TOTAL_W-1:0];
  assign i_last = SYM_W'(ALPHABET - 1);

  always_comb begin
    state_d = state_q;
    op_d = op_q; sym_d = sym_q; last_d = last_q;
    used_d = used_q; pcur_d = pcur_q; failed_d = failed_q;
    tcur_d = tcur_q; total_d = total_q;
    head_d = head_q; tail_d = tail_q;
    u_d = u_q; fu_d = fu_q; v_d = v_q; l_d = l_q; j_d = j_q; i_d = i_q;
    rstat_d = rstat_q; rtot_d = rtot_q;
    ovalid_d = ovalid_q; ostat_d = ostat_q; otot_d = otot_q; olast_d = olast_q;
    nx = rsp_i.child;
    pf = failed_q;
    req_o = '0;

    // Drop the result once taken
    if (ovalid_q && out_ready_i) ovalid_d = 1'b0;

    case (state_q)
      S_IDLE: begin
        if (in_acc) begin
          op_d   = operation_i;
          sym_d  = (32'(symbol_i) >= ALPHABET) ? i_last : symbol_i;
          last_d = last_i;
          state_d = ((operation_i == OP_INSERT) || (operation_i == OP_DELETE))
                    ? S_P_RD : S_T_RD;
        end
      end
      // Pattern: step the cursor, allocate on insert
      S_P_RD: begin
        req_o.child_raddr = child_idx(pcur_q, sym_q);
        state_d = S_P_CHK;
      end
      S_P_CHK: begin
        if (!failed_q) begin
          if (nx == '0 && op_q == OP_INSERT && 32'(used_q) < MAX_NODES) begin
            nx = used_q[NODE_W-1:0];
            used_d = used_q + 1'b1;
            req_o.child_we    = 1'b1;
            req_o.child_waddr = child_idx(pcur_q, sym_q);
            req_o.child_wdata = nx;
          end
          if (nx == '0) pf = 1'b1;
          else pcur_d = nx;
        end
        failed_d = pf;
        req_o.own_raddr = pcur_d;
        rstat_d = pf ? code : ST_OK;
        rtot_d  = '0;
        if (last_q && !pf) state_d = S_P_CNT;
        else if (last_q) state_d = S_B_INI;
        else state_d = S_FIN;
      end
      // Pattern end: adjust the end count
      S_P_CNT: begin
        req_o.own_waddr = pcur_q;
        if (op_q == OP_INSERT) begin
          req_o.own_we    = rsp_i.own != '1;
          req_o.own_wdata = rsp_i.own + 1'b1;
        end else if (rsp_i.own != '0) begin
          req_o.own_we    = 1'b1;
          req_o.own_wdata = rsp_i.own - 1'b1;
        end else begin
          rstat_d = code;
        end
        state_d = S_B_INI;
      end
      // Text: follow goto, else failure links
      S_T_RD: begin
        req_o.child_raddr = child_idx(tcur_q, sym_q);
        state_d = S_T_CHK;
      end
      S_T_CHK: begin
        if (nx != '0) begin
          tcur_d = nx;
          req_o.prop_raddr = nx;
          state_d = S_T_ADD;
        end else if (tcur_q == '0) begin
          req_o.prop_raddr = '0;
          state_d = S_T_ADD;
        end else begin
          req_o.fail_raddr = tcur_q;
          state_d = S_T_FL;
        end
      end
      S_T_FL: begin
        tcur_d  = rsp_i.fail;
        state_d = S_T_RD;
      end
      S_T_ADD: begin
        rstat_d = ST_OK;
        rtot_d  = tsat;
        if (last_q) begin
          tcur_d = '0; total_d = '0;
        end else begin
          total_d = tsat;
        end
        state_d = S_FIN;
      end
      // Rebuild: seed the queue with the root
      S_B_INI: begin
        req_o.q_we = 1'b1; req_o.q_waddr = '0; req_o.q_wdata = '0;
        head_d = '0; tail_d = USED_W'(1);
        state_d = S_B_POP;
      end
      S_B_POP: begin
        if (head_q < tail_q) begin
          req_o.q_raddr = head_q[NODE_W-1:0];
          head_d = head_q + 1'b1;
          state_d = S_B_U;
        end else begin
          pcur_d = '0; failed_d = 1'b0;
          state_d = S_FIN;
        end
      end
      S_B_U: begin
        u_d = rsp_i.q;
        req_o.fail_raddr = rsp_i.q;
        i_d = '0;
        state_d = S_B_FU;
      end
      S_B_FU: begin
        fu_d = rsp_i.fail;
        state_d = S_B_C;
      end
      S_B_C: begin
        req_o.child_raddr = child_idx(u_q, i_q);
        state_d = S_B_V;
      end
      S_B_V: begin
        v_d = nx;
        if (nx == '0) begin
          if (i_q == i_last) state_d = S_B_POP;
          else begin
            i_d = i_q + 1'b1; state_d = S_B_C;
          end
        end else if (u_q == '0) begin
          l_d = '0; state_d = S_B_P;
        end else begin
          j_d = fu_q;
          req_o.child_raddr = child_idx(fu_q, i_q);
          state_d = S_B_JC;
        end
      end
      // Chase failure links for the child's link target
      S_B_JC: begin
        if (nx != '0) begin
          l_d = nx; state_d = S_B_P;
        end else if (j_q == '0) begin
          l_d = '0; state_d = S_B_P;
        end else begin
          req_o.fail_raddr = j_q;
          state_d = S_B_JF;
        end
      end
      S_B_JF: begin
        j_d = rsp_i.fail;
        req_o.child_raddr = child_idx(rsp_i.fail, i_q);
        state_d = S_B_JC;
      end
      S_B_P: begin
        req_o.fail_we = 1'b1; req_o.fail_waddr = v_q; req_o.fail_wdata = l_q;
        req_o.own_raddr  = v_q;
        req_o.prop_raddr = l_q;
        state_d = S_B_W;
      end
      S_B_W: begin
        req_o.prop_we    = 1'b1;
        req_o.prop_waddr = v_q;
        req_o.prop_wdata = psum[COUNT_W] ? '1 : psum[COUNT_W-1:0];
        if (32'(tail_q) < MAX_NODES) begin
          req_o.q_we = 1'b1; req_o.q_waddr = tail_q[NODE_W-1:0]; req_o.q_wdata = v_q;
          tail_d = tail_q + 1'b1;
        end
        if (i_q == i_last) state_d = S_B_POP;
        else begin
          i_d = i_q + 1'b1; state_d = S_B_C;
        end
      end
      // Hand the word to the output register when free
      S_FIN: begin
        if (!ovalid_q || out_ready_i) begin
          ovalid_d = 1'b1;
          ostat_d  = rstat_q;
          otot_d   = rtot_q;
          olast_d  = last_q;
          state_d  = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= S_IDLE;
      used_q   <= USED_W'(1);
      pcur_q   <= '0;
      failed_q <= 1'b0;
      tcur_q   <= '0;
      total_q  <= '0;
      head_q   <= '0;
      tail_q   <= '0;
      ovalid_q <= 1'b0;
    end else begin
      state_q  <= state_d;
      used_q   <= used_d;
      pcur_q   <= pcur_d;
      failed_q <= failed_d;
      tcur_q   <= tcur_d;
      total_q  <= total_d;
      head_q   <= head_d;
      tail_q   <= tail_d;
      ovalid_q <= ovalid_d;
    end
  end

  // Payload registers
  always_ff @(posedge clk_i) begin
    op_q <= op_d; sym_q <= sym_d; last_q <= last_d;
    u_q <= u_d; fu_q <= fu_d; v_q <= v_d; l_q <= l_d; j_q <= j_d; i_q <= i_d;
    rstat_q <= rstat_d; rtot_q <= rtot_d;
    ostat_q <= ostat_d; otot_q <= otot_d; olast_q <= olast_d;
  end

  assign out_valid_o   = ovalid_q;
  assign status_o      = ostat_q;
  assign match_total_o = otot_q;
  assign result_last_o = olast_q;

  `MPMC_ASSERT(a_used_range, (used_q != '0) && (32'(used_q) <= MAX_NODES))
  `MPMC_ASSERT_IMP(a_queue_order, state_q == S_B_POP, head_q <= tail_q)
  `MPMC_ASSERT(a_busy_after_accept, in_acc |=> !in_ready_o)
  `MPMC_ASSERT_IMP(a_text_ok, state_q == S_FIN && !is_pat, rstat_q == ST_OK)

endmodule

// ----- tb/multi_pattern_match_counter_tb.sv -----
// ----------------------------------------------------------------------------
// multi_pattern_match_counter_tb
// Drives pattern inserts, pattern deletes and text words into the match
// counter with random gaps on both sides. A scoreboard keeps its own trie,
// failure links and counts, works out the result of every accepted word, and
// compares each returned word field by field with the oldest expectation.
// ----------------------------------------------------------------------------
module multi_pattern_match_counter_tb;
  timeunit 1ns;
  timeprecision 1ps;

  import mpmc_pkg::*;

  localparam logic [OP_W-1:0] OP_TEXT     = 2'd2;
  localparam logic [OP_W-1:0] OP_TEXT_ALT = 2'd3;
  localparam int  END_WAIT    = 2000;
  localparam longint CYCLE_LIMIT = 12_000_000;
  localparam logic [TOTAL_W-1:0] TOTAL_SAT = '1;
  localparam logic [COUNT_W-1:0] COUNT_SAT = '1;

  typedef struct {
    logic [STATUS_W-1:0] status;
    logic [TOTAL_W-1:0]  total;
    logic                last;
  } match_result_t;

  // Trie, links and counts mirrored word by word.
  class match_scoreboard;
    logic [NODE_W-1:0]  kids [CHILD_DEPTH];
    logic [NODE_W-1:0]  fail_lnk [MAX_NODES];
    logic [COUNT_W-1:0] own_cnt [MAX_NODES];
    logic [COUNT_W-1:0] prop_cnt [MAX_NODES];
    int                 bfs [MAX_NODES];
    int                 used_nodes;
    int                 pat_node;
    bit                 pat_bad;
    int                 txt_node;
    logic [TOTAL_W-1:0] run_total;
    match_result_t      pending_q [$];
    int                 errors;
    int                 checked;
    int                 full_seen;
    int                 missing_seen;

    function void clear();
      foreach (kids[i]) kids[i] = '0;
      foreach (fail_lnk[i]) begin
        fail_lnk[i] = '0;
        own_cnt[i]  = '0;
        prop_cnt[i] = '0;
      end
      used_nodes = 1;
      pat_node = 0;
      pat_bad = 0;
      txt_node = 0;
      run_total = '0;
      errors = 0;
      checked = 0;
      full_seen = 0;
      missing_seen = 0;
    endfunction

    function int pending();
      return pending_q.size();
    endfunction

    // Walk the trie breadth first and relink every node.
    function void relink();
      int head;
      int tail;
      int u;
      int v;
      int lnk;
      int j;
      int c;
      int sum;
      head = 0;
      tail = 0;
      fail_lnk[0] = '0;
      prop_cnt[0] = '0;
      bfs[tail++] = 0;
      while (head < tail) begin
        u = bfs[head++];
        for (int s = 0; s < ALPHABET; s++) begin
          v = kids[u*ALPHABET+s];
          if (v == 0) continue;
          lnk = 0;
          if (u != 0) begin
            j = fail_lnk[u];
            for (int n = 0; n <= MAX_NODES; n++) begin
              c = kids[j*ALPHABET+s];
              if (c != 0) begin
                lnk = c;
                break;
              end
              if (j == 0) break;
              j = fail_lnk[j];
            end
          end
          fail_lnk[v] = lnk;
          sum = own_cnt[v] + prop_cnt[lnk];
          prop_cnt[v] = (sum > COUNT_SAT) ? COUNT_SAT : COUNT_W'(sum);
          if (tail < MAX_NODES) bfs[tail++] = v;
        end
      end
    endfunction

    // Work out the result of one accepted word.
    function void note_word(logic [OP_W-1:0] op, logic [SYM_W-1:0] sym_in, logic lst);
      match_result_t r;
      int sym;
      int nx;
      int cur;
      logic [TOTAL_W:0] acc;
      sym = (sym_in >= ALPHABET) ? ALPHABET - 1 : int'(sym_in);
      r.status = ST_OK;
      r.total = '0;
      r.last = lst;
      if (op == OP_INSERT || op == OP_DELETE) begin
        if (!pat_bad) begin
          nx = kids[pat_node*ALPHABET+sym];
          if (nx == 0 && op == OP_INSERT && used_nodes < MAX_NODES) begin
            nx = used_nodes++;
            kids[pat_node*ALPHABET+sym] = NODE_W'(nx);
          end
          if (nx == 0) pat_bad = 1;
          else pat_node = nx;
        end
        if (lst && !pat_bad) begin
          if (op == OP_INSERT) begin
            if (own_cnt[pat_node] != COUNT_SAT) own_cnt[pat_node]++;
          end else if (own_cnt[pat_node] != 0) begin
            own_cnt[pat_node]--;
          end else begin
            pat_bad = 1;
          end
        end
        if (pat_bad) begin
          r.status = (op == OP_INSERT) ? ST_FULL : ST_MISSING;
          if (op == OP_INSERT) full_seen++;
          else missing_seen++;
        end
        if (lst) begin
          relink();
          pat_node = 0;
          pat_bad = 0;
        end
      end else begin
        cur = txt_node;
        for (int n = 0; n <= MAX_NODES; n++) begin
          nx = kids[cur*ALPHABET+sym];
          if (nx != 0) begin
            cur = nx;
            break;
          end
          if (cur == 0) break;
          cur = fail_lnk[cur];
        end
        txt_node = cur;
        acc = {1'b0, run_total} + prop_cnt[cur];
        run_total = acc[TOTAL_W] ? TOTAL_SAT : acc[TOTAL_W-1:0];
        r.total = run_total;
        if (lst) begin
          txt_node = 0;
          run_total = '0;
        end
      end
      pending_q.insert(pending_q.size(), r);
    endfunction

    task report(string what, longint got, longint want);
      $display("[%0t] mismatch on %s: got %0d, expected %0d", $time, what, got, want);
      errors++;
    endtask

    // Compare one returned word with the oldest expectation.
    task check_word(logic [STATUS_W-1:0] st, logic [TOTAL_W-1:0] tot, logic lst);
      match_result_t r;
      if (pending_q.size() == 0) begin
        report("unexpected word", 1, 0);
        return;
      end
      r = pending_q.pop_front();
      checked++;
      if (st !== r.status) report("status", st, r.status);
      if (tot !== r.total) report("match_total", tot, r.total);
      if (lst !== r.last) report("result_last", lst, r.last);
    endtask
  endclass

  logic                clk_i;
  logic                rst_ni;
  logic                in_valid_i;
  logic                in_ready_o;
  logic [OP_W-1:0]     operation_i;
  logic [SYM_W-1:0]    symbol_i;
  logic                last_i;
  logic                out_valid_o;
  logic                out_ready_i;
  logic [STATUS_W-1:0] status_o;
  logic [TOTAL_W-1:0]  match_total_o;
  logic                result_last_o;

  match_scoreboard sb;
  bit      burst;
  int      stall_left;
  int      words_sent;
  longint  cycles;
  logic [SYM_W-1:0] held_pat [$][$];

  multi_pattern_match_counter DUT (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .in_valid_i    (in_valid_i),
    .in_ready_o    (in_ready_o),
    .operation_i   (operation_i),
    .symbol_i      (symbol_i),
    .last_i        (last_i),
    .out_valid_o   (out_valid_o),
    .out_ready_i   (out_ready_i),
    .status_o      (status_o),
    .match_total_o (match_total_o),
    .result_last_o (result_last_o)
  );

  always #4 clk_i = ~clk_i;

  // Bound the run.
  always @(posedge clk_i) begin
    cycles++;
    if (cycles > CYCLE_LIMIT) begin
      $display("timeout after %0d cycles, %0d words outstanding", cycles, sb.pending());
      $display("multi_pattern_match_counter_tb failed");
      $finish;
    end
  end

  // Offer one word and hold it until taken.
  task send_word(logic [OP_W-1:0] op, logic [SYM_W-1:0] sym, logic lst);
    int gap;
    gap = burst ? 0 : $urandom_range(0, 12);
    repeat (gap) @(negedge clk_i);
    operation_i = op;
    symbol_i = sym;
    last_i = lst;
    in_valid_i = 1'b1;
    do @(posedge clk_i); while (!in_ready_o);
    sb.note_word(op, sym, lst);
    words_sent++;
    @(negedge clk_i);
    in_valid_i = 1'b0;
  endtask

  task send_pattern(logic [OP_W-1:0] op, logic [SYM_W-1:0] syms [$]);
    foreach (syms[i]) send_word(op, syms[i], i == syms.size() - 1);
  endtask

  task send_text(logic [SYM_W-1:0] syms [$]);
    foreach (syms[i])
      send_word(($urandom_range(0, 7) == 0) ? OP_TEXT_ALT : OP_TEXT, syms[i],
                i == syms.size() - 1);
  endtask

  // Hold until every expected word has come back.
  task drain();
    while (sb.pending() != 0) @(negedge clk_i);
  endtask

  // Receiver: random gaps, plus a long hold-off when asked.
  initial begin
    int gap;
    out_ready_i = 1'b0;
    @(posedge rst_ni);
    forever begin
      gap = burst ? 0 : $urandom_range(0, 12);
      repeat (gap) @(negedge clk_i);
      while (stall_left > 0) @(negedge clk_i);
      out_ready_i = 1'b1;
      do @(posedge clk_i); while (!out_valid_o);
      sb.check_word(status_o, match_total_o, result_last_o);
      @(negedge clk_i);
      out_ready_i = 1'b0;
    end
  end

  // Count down the hold-off in its own process.
  always @(negedge clk_i) if (stall_left > 0) stall_left <= stall_left - 1;

  initial begin
    logic [SYM_W-1:0] syms [$];
    int kind;
    int len;
    int pick;
    sb = new();
    sb.clear();
    clk_i = 1'b0;
    rst_ni = 1'b0;
    in_valid_i = 1'b0;
    operation_i = OP_INSERT;
    symbol_i = '0;
    last_i = 1'b0;
    burst = 0;
    stall_left = 0;
    words_sent = 0;
    cycles = 0;
    repeat (10) @(negedge clk_i);
    rst_ni = 1'b1;

    // Directed: overlapping patterns, deletes, failures, mixed and odd codes.
    send_pattern(OP_INSERT, '{0});
    send_pattern(OP_INSERT, '{0, 1});
    send_pattern(OP_INSERT, '{1});
    send_text('{0, 1, 0, 1});
    send_pattern(OP_INSERT, '{25});
    send_pattern(OP_INSERT, '{31});
    send_text('{31, 25});
    send_pattern(OP_DELETE, '{0, 1});
    send_pattern(OP_DELETE, '{0, 1});
    send_pattern(OP_DELETE, '{16});
    send_word(OP_INSERT, 0, 0);
    send_word(OP_DELETE, 7, 0);
    send_word(OP_INSERT, 2, 1);
    send_word(OP_INSERT, 2, 0);
    send_word(OP_TEXT, 2, 0);
    send_word(OP_TEXT_ALT, 0, 1);
    send_word(OP_INSERT, 0, 1);
    send_text('{2, 0, 2, 0});

    // Random: mostly texts over a small letter set, with patterns and deletes.
    while (words_sent < 1950) begin
      if ($urandom_range(0, 19) == 0) burst = ~burst;
      if (words_sent > 600 && words_sent < 610 && stall_left == 0) stall_left = 400;
      if (words_sent > 1200 && words_sent < 1206) drain();
      kind = $urandom_range(0, 99);
      syms = {};
      if (kind < 18) begin
        len = $urandom_range(1, 3);
        repeat (len) syms.insert(syms.size(), SYM_W'($urandom_range(0, 2)));
        held_pat.insert(held_pat.size(), syms);
        send_pattern(OP_INSERT, syms);
      end else if (kind < 26 && held_pat.size() > 0) begin
        pick = $urandom_range(0, held_pat.size() - 1);
        send_pattern(OP_DELETE, held_pat[pick]);
        held_pat.delete(pick);
      end else if (kind < 30) begin
        len = $urandom_range(1, 3);
        repeat (len) syms.insert(syms.size(), SYM_W'($urandom_range(0, 31)));
        foreach (syms[i])
          send_word($urandom_range(0, 3) == 0 ? OP_DELETE : OP_INSERT, syms[i],
                    i == syms.size() - 1);
      end else begin
        len = $urandom_range(1, 12);
        repeat (len)
          syms.insert(syms.size(),
                      $urandom_range(0, 9) == 0 ? SYM_W'($urandom_range(0, 31))
                                                : SYM_W'($urandom_range(0, 2)));
        send_text(syms);
      end
    end

    // Drain and close.
    drain();
    repeat (END_WAIT) @(negedge clk_i);
    $display("covered %0d words checked, %0d store-full and %0d missing-pattern results",
             sb.checked, sb.full_seen, sb.missing_seen);
    $display("final trie size %0d nodes after %0d cycles", sb.used_nodes, cycles);
    if (sb.errors == 0 && sb.pending() == 0) begin
      $display("multi_pattern_match_counter_tb passed");
    end else begin
      $display("multi_pattern_match_counter_tb failed");
    end
    $finish;
  end

endmodule
